[sv/sound_level_color_smoother_defines.svh]
// Assertion macros for the sound level color smoother.
`ifndef SOUND_LEVEL_COLOR_SMOOTHER_DEFINES_SVH
`define SOUND_LEVEL_COLOR_SMOOTHER_DEFINES_SVH

`ifndef ASSERT_OFF
`define SLCS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slcs check failed");
`define SLCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slcs check failed");
`else
`define SLCS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SLCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[sv/slcs_pkg.sv]
package slcs_pkg;

    localparam int WINDOW_LEN = 8;
    localparam int LEVEL_W    = 11;
    localparam int DUTY_W     = 8;
    localparam int SUM_W      = $clog2(2 * WINDOW_LEN + 1);
    localparam int CMP_W      = SUM_W + 5;

    localparam logic [LEVEL_W-1:0] GREEN_LIMIT_RST  = LEVEL_W'(650);
    localparam logic [LEVEL_W-1:0] YELLOW_LIMIT_RST = LEVEL_W'(850);

    localparam logic REG_GREEN_LIMIT  = 1'b0;
    localparam logic REG_YELLOW_LIMIT = 1'b1;

    localparam logic [CMP_W-1:0] GREEN_BOUND  = CMP_W'(WINDOW_LEN);
    localparam logic [CMP_W-1:0] YELLOW_BOUND = CMP_W'(14 * WINDOW_LEN);

    localparam logic [DUTY_W-1:0] DUTY_ON     = DUTY_W'(0);
    localparam logic [DUTY_W-1:0] DUTY_OFF    = DUTY_W'(255);
    localparam logic [DUTY_W-1:0] DUTY_YELLOW = DUTY_W'(100);

    typedef enum logic [1:0] {
        COLOR_GREEN  = 2'd0,
        COLOR_YELLOW = 2'd1,
        COLOR_RED    = 2'd2
    } color_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

[sv/slcs_front.sv]
module slcs_front
    import slcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [LEVEL_W-1:0] cfg_wdata,
    input  logic [LEVEL_W-1:0] level,
    output color_t             color
);

    logic [LEVEL_W-1:0] green_limit_reg;
    logic [LEVEL_W-1:0] yellow_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            green_limit_reg  <= GREEN_LIMIT_RST;
            yellow_limit_reg <= YELLOW_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_GREEN_LIMIT)
                green_limit_reg <= cfg_wdata;
            if (cfg_index == REG_YELLOW_LIMIT)
                yellow_limit_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        priority if (level < green_limit_reg)
            color = COLOR_GREEN;
        else if (level < yellow_limit_reg)
            color = COLOR_YELLOW;
        else
            color = COLOR_RED;
    end

endmodule

[sv/slcs_fifo.sv]
module slcs_fifo
    import slcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  color_t     push_color,
    input  logic       pop,
    output color_t     pop_color,
    output fifo_stat_t stat
);

    color_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_color;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    assign pop_color  = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);

endmodule

[sv/slcs_back.sv]
module slcs_back
    import slcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  color_t            in_color,
    output logic              pop,
    input  logic              out_ready,
    output logic              out_valid,
    output color_t            shown_color,
    output logic [DUTY_W-1:0] red_duty,
    output logic [DUTY_W-1:0] green_duty,
    output logic [DUTY_W-1:0] blue_duty
);

    color_t           window_reg [WINDOW_LEN];
    logic             window_empty_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic             out_valid_reg;
    color_t           shown_reg;
    color_t           shown_next;
    color_t           newest;
    color_t           oldest;
    logic             refill;
    logic [CMP_W-1:0] sum_x2;
    logic [CMP_W-1:0] sum_x10;

    assign pop    = in_valid && (!out_valid_reg || out_ready);
    assign newest = window_reg[WINDOW_LEN-1];
    assign oldest = window_reg[0];
    assign refill = window_empty_reg || (in_color < newest);

    always_comb
    begin
        if (refill)
            sum_next = SUM_W'(in_color) * SUM_W'(WINDOW_LEN);
        else
            sum_next = sum_reg - SUM_W'(oldest) + SUM_W'(in_color);
        sum_x2  = CMP_W'(sum_next) * CMP_W'(2);
        sum_x10 = CMP_W'(sum_next) * CMP_W'(10);
    end

    always_comb
    begin
        priority if (refill)
            shown_next = in_color;
        else if (in_color == COLOR_RED && (newest == COLOR_GREEN || newest == COLOR_RED))
            shown_next = COLOR_RED;
        else if (sum_x2 < GREEN_BOUND)
            shown_next = COLOR_GREEN;
        else if (sum_x10 < YELLOW_BOUND)
            shown_next = COLOR_YELLOW;
        else
            shown_next = COLOR_RED;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int i = 0; i < WINDOW_LEN - 1; i++)
            begin
                if (refill)
                    window_reg[i] <= in_color;
                else
                    window_reg[i] <= window_reg[i+1];
            end
            window_reg[WINDOW_LEN-1] <= in_color;
            sum_reg   <= sum_next;
            shown_reg <= shown_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_empty_reg <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (pop)
                window_empty_reg <= 1'b0;
            if (pop)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        unique case (shown_reg)
            COLOR_GREEN:
            begin
                red_duty   = DUTY_OFF;
                green_duty = DUTY_ON;
            end
            COLOR_YELLOW:
            begin
                red_duty   = DUTY_ON;
                green_duty = DUTY_YELLOW;
            end
            default:
            begin
                red_duty   = DUTY_ON;
                green_duty = DUTY_OFF;
            end
        endcase
    end

    assign blue_duty   = DUTY_OFF;
    assign out_valid   = out_valid_reg;
    assign shown_color = shown_reg;

endmodule

[sv/sound_level_color_smoother.sv]
// Accepted words pass through a two-entry queue, which decouples classify
// from smoothing, then the output register. Throughput: one word per cycle
// unless m_tready stalls the output; the window shift register and running
// sum update once per word. Reset (rst_n low, asynchronous): limits return to
// 650 and 850, the window is marked empty, queue and out_valid are cleared.
`include "sound_level_color_smoother_defines.svh"

module sound_level_color_smoother
    import slcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // [10:0] level_tenth_db
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,   // [1:0] shown_color, [9:2] red_duty,
                                          // [17:10] green_duty, [25:18] blue_duty
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [LEVEL_W-1:0] cfg_wdata
);

    color_t            front_color;
    color_t            queue_color;
    fifo_stat_t        queue_stat;
    logic              push;
    logic              pop;
    color_t            shown_color;
    logic [DUTY_W-1:0] red_duty;
    logic [DUTY_W-1:0] green_duty;
    logic [DUTY_W-1:0] blue_duty;

    assign s_tready = !queue_stat.full;
    assign push     = s_tvalid && s_tready;

    slcs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .level     (s_tdata[LEVEL_W-1:0]),
        .color     (front_color)
    );

    slcs_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_color (front_color),
        .pop        (pop),
        .pop_color  (queue_color),
        .stat       (queue_stat)
    );

    slcs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (!queue_stat.empty),
        .in_color    (queue_color),
        .pop         (pop),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .shown_color (shown_color),
        .red_duty    (red_duty),
        .green_duty  (green_duty),
        .blue_duty   (blue_duty)
    );

    assign m_tdata = {6'd0, blue_duty, green_duty, red_duty, shown_color};

    `SLCS_ASSERT_NEXT(a_pop_fills_output, clk, rst_n, pop, m_tvalid)
    `SLCS_ASSERT_NEXT(a_push_reaches_queue, clk, rst_n, push, !queue_stat.empty)
    `SLCS_ASSERT_SAME(a_red_duties, clk, rst_n,
        m_tvalid && shown_color == COLOR_RED,
        red_duty == DUTY_ON && green_duty == DUTY_OFF)
    `SLCS_ASSERT_SAME(a_color_legal, clk, rst_n, m_tvalid,
        shown_color == COLOR_GREEN || shown_color == COLOR_YELLOW || shown_color == COLOR_RED)

endmodule

[verif/smoother_checker.sv]
`timescale 1ns / 100ps

module smoother_checker
    import slcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [15:0]        s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [31:0]        m_tdata,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [LEVEL_W-1:0] cfg_wdata,
    output int                 mismatches,
    output int                 in_flight,
    output int                 results_seen
);

    typedef struct packed {
        color_t              color;
        logic [DUTY_W-1:0]   red;
        logic [DUTY_W-1:0]   green;
        logic [DUTY_W-1:0]   blue;
    } led_word_t;

    logic [LEVEL_W-1:0] green_lim;
    logic [LEVEL_W-1:0] yellow_lim;
    logic [1:0]         history [WINDOW_LEN];
    logic               history_blank;
    led_word_t          expected_leds [$];

    function automatic color_t classify_level(input logic [LEVEL_W-1:0] lvl);
        if (lvl < green_lim)
            return COLOR_GREEN;
        if (lvl < yellow_lim)
            return COLOR_YELLOW;
        return COLOR_RED;
    endfunction

    function automatic color_t smooth_color(input color_t c);
        color_t newest;
        int     sum;
        int     idx;
        newest = color_t'(history[WINDOW_LEN-1]);
        if (history_blank || c < newest)
        begin
            for (idx = 0; idx < WINDOW_LEN; idx++)
                history[idx] = c;
            history_blank = 1'b0;
            return c;
        end
        for (idx = 0; idx < WINDOW_LEN - 1; idx++)
            history[idx] = history[idx+1];
        history[WINDOW_LEN-1] = c;
        if (c == COLOR_RED && (newest == COLOR_GREEN || newest == COLOR_RED))
            return c;
        sum = 0;
        for (idx = 0; idx < WINDOW_LEN; idx++)
            sum += history[idx];
        if (2 * sum < WINDOW_LEN)
            return COLOR_GREEN;
        if (10 * sum < 14 * WINDOW_LEN)
            return COLOR_YELLOW;
        return COLOR_RED;
    endfunction

    function automatic led_word_t leds_for(input color_t c);
        led_word_t w;
        w.color = c;
        w.blue  = DUTY_OFF;
        case (c)
            COLOR_GREEN:
            begin
                w.red   = DUTY_OFF;
                w.green = DUTY_ON;
            end
            COLOR_YELLOW:
            begin
                w.red   = DUTY_ON;
                w.green = DUTY_YELLOW;
            end
            default:
            begin
                w.red   = DUTY_ON;
                w.green = DUTY_OFF;
            end
        endcase
        return w;
    endfunction

    function automatic int field_ok(input string fname, input int want, input int seen);
        if (want == seen)
            return 0;
        $display("%0t ns: %s expected %0d actual %0d", $time, fname, want, seen);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        led_word_t want;
        led_word_t seen;
        if (!rst_n)
        begin
            green_lim     = GREEN_LIMIT_RST;
            yellow_lim    = YELLOW_LIMIT_RST;
            history_blank = 1'b1;
            expected_leds.delete();
            mismatches    = 0;
            in_flight     = 0;
            results_seen  = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_leds.push_back(
                    leds_for(smooth_color(classify_level(s_tdata[LEVEL_W-1:0]))));
            if (m_tvalid && m_tready)
            begin
                seen.color = color_t'(m_tdata[1:0]);
                seen.red   = m_tdata[9:2];
                seen.green = m_tdata[17:10];
                seen.blue  = m_tdata[25:18];
                results_seen++;
                if (expected_leds.size() == 0)
                begin
                    $display("%0t ns: word expected none actual %h", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_leds.pop_front();
                    mismatches += field_ok("shown_color", want.color, seen.color);
                    mismatches += field_ok("red_duty", want.red, seen.red);
                    mismatches += field_ok("green_duty", want.green, seen.green);
                    mismatches += field_ok("blue_duty", want.blue, seen.blue);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GREEN_LIMIT:  green_lim  = cfg_wdata;
                    REG_YELLOW_LIMIT: yellow_lim = cfg_wdata;
                    default:          ;
                endcase
            end
            in_flight = expected_leds.size();
        end
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
    import slcs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 48;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [15:0]        s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [31:0]        m_tdata;
    logic               cfg_we;
    logic               cfg_index;
    logic [LEVEL_W-1:0] cfg_wdata;

    int mismatches;
    int in_flight;
    int results_seen;
    int cycles = 0;
    int words_sent;
    int settings_used;
    bit quiet;
    int g_cur;
    int y_cur;

    sound_level_color_smoother dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    smoother_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .in_flight    (in_flight),
        .results_seen (results_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("sound_level_color_smoother: mismatch");
            $finish;
        end
    end

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= LEVEL_W'(val);
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // hold off the sender until every word has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (in_flight != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_limits(input int g, input int y);
        drain();
        write_reg(REG_GREEN_LIMIT, g);
        write_reg(REG_YELLOW_LIMIT, y);
        g_cur = g;
        y_cur = y;
        settings_used++;
    endtask

    task automatic send_level(input int lvl);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, LEVEL_W'(lvl)};
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
        @(negedge clk);
    endtask

    function automatic int pick_level(input int cls);
        int lo;
        int hi;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 2047);
        case (cls)
            0:
            begin
                lo = 0;
                hi = g_cur - 1;
            end
            1:
            begin
                lo = g_cur;
                hi = y_cur - 1;
            end
            default:
            begin
                lo = (g_cur > y_cur) ? g_cur : y_cur;
                hi = 2047;
            end
        endcase
        if (hi < lo)
            return $urandom_range(0, 2047);
        case ($urandom_range(0, 5))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    int plan_g [PHASES] = '{650, 0, 2047, 900, 0, 2047, 120, 0};
    int plan_y [PHASES] = '{850, 2047, 2047, 300, 0, 0, 1900, 0};
    int directed [20] = '{0, 2047, 649, 650, 700, 849, 850, 849, 2047, 0,
                          650, 650, 650, 650, 1024, 2047, 1, 1365, 682, 851};

    initial
    begin
        int cls;
        int p;
        int k;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_GREEN_LIMIT;
        cfg_wdata     = '0;
        quiet         = 1'b0;
        words_sent    = 0;
        settings_used = 0;
        cls           = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_limits(650, 850);
        for (k = 0; k < 20; k++)
            send_level(directed[k]);

        for (p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
            begin
                set_limits($urandom_range(0, 2047), $urandom_range(0, 2047));
                quiet = 1'b1;
            end
            else
            begin
                set_limits(plan_g[p], plan_y[p]);
            end
            for (k = 0; k < PHASE_WORDS; k++)
            begin
                if ($urandom_range(0, 99) < 30)
                    cls = $urandom_range(0, 2);
                send_level(pick_level(cls));
                if (p == 3 && k == PHASE_WORDS / 2)
                    drain();
            end
        end

        drain();
        repeat (10) @(negedge clk);
        $display("%0d levels sent under %0d limit settings, %0d result words checked",
                 words_sent, settings_used, results_seen);
        $display("settings included zero, full-scale and out-of-order limits");
        if (mismatches == 0 && in_flight == 0)
            $display("sound_level_color_smoother: match");
        else
            $display("sound_level_color_smoother: mismatch");
        $finish;
    end

endmodule
